/* hw/rtl/full_tree_height_count_unit_macros.svh */
// Assertion macros for the full tree height count unit.
// Used by the RTL modules; each expects clk and rst in scope.
`ifndef FULL_TREE_HEIGHT_COUNT_UNIT_MACROS_SVH
`define FULL_TREE_HEIGHT_COUNT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define FTC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define FTC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ftc_pkg.sv */
// Shared constants and types for the full tree height count unit.
// No dependencies; imported by ftc_mac and full_tree_height_count_unit.
`default_nettype none

package ftc_pkg;

  localparam int MAX_NODES  = 256;
  localparam int MAX_HEIGHT = 128;
  localparam int N_W        = $clog2(MAX_NODES);
  localparam int H_W        = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = N_W + H_W;
  localparam int MEMO_DEPTH = MAX_NODES * MAX_HEIGHT;
  localparam int RES_W      = 14;
  localparam logic [RES_W-1:0] MODULUS = RES_W'(9901);

  // raw sum of up to MAX_NODES/2 products of two residues
  localparam int ACC_W = 2 * RES_W + $clog2(MAX_NODES / 2);

  // reduction of the raw sum: bits above FOLD_SH fold back in times
  // 2^FOLD_SH mod 9901, a reciprocal multiply then gives the quotient
  // low by at most one, and one compare-subtract finishes
  localparam int FOLD_SH   = 20;
  localparam int FOLD_W    = ACC_W - FOLD_SH + RES_W + 1;
  localparam logic [RES_W-1:0] FOLD_K = RES_W'((1 << FOLD_SH) % int'(MODULUS));
  localparam int RECIP_SH  = 42;
  localparam int RECIP_W   = 29;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((longint'(1) << RECIP_SH) / longint'(MODULUS));
  localparam int Q_W       = FOLD_W + RECIP_W - RECIP_SH;
  localparam int RED_STEPS = 3;

  typedef struct packed {
    logic issue;   // one product term enters the pipe
    logic clr;     // clear accumulator
    logic red_go;  // start reduction of the accumulator
    logic hz;      // term height is zero: both operands count as 0
    logic a_one;   // left subtree is a single node
    logic b_one;   // right subtree is a single node
  } ftc_mac_ctl_t;

  typedef struct packed {
    logic             pipe_empty;
    logic             red_busy;
    logic [RES_W-1:0] residue;
  } ftc_mac_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/ftc_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module ftc_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* hw/rtl/ftc_mac.sv */
// Shared multiply-accumulate unit with a short mod-9901 reducer.
// Depends on ftc_pkg and the assertion macro header.
`default_nettype none
`include "full_tree_height_count_unit_macros.svh"

module ftc_mac (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ftc_pkg::ftc_mac_ctl_t     ctl,
  input  wire logic [ftc_pkg::RES_W-1:0] rdata_a,
  input  wire logic [ftc_pkg::RES_W-1:0] rdata_b,
  output ftc_pkg::ftc_mac_sts_t          sts
);
  import ftc_pkg::*;

  logic                      p1_v, p1_hz, p1_a_one, p1_b_one;
  logic                      p2_v;
  logic [2*RES_W-1:0]        prod;
  logic [ACC_W-1:0]          acc;
  logic [RES_W-1:0]          a_val, b_val;
  logic [RED_STEPS-1:0]      stg;       // one-hot reduction step
  logic [FOLD_W-1:0]         fold, fold_next;
  logic [FOLD_W+RECIP_W-1:0] recip_prod;
  logic [Q_W-1:0]            quo, quo_mul;
  logic [RES_W:0]            part, part_next, part_sub;
  logic [RES_W-1:0]          rem;
  logic                      red_busy;

  // operand select: level zero gives 0, single node gives 1, else memo
  always_comb begin
    a_val = p1_hz ? '0 : (p1_a_one ? RES_W'(1) : rdata_a);
    b_val = p1_hz ? '0 : (p1_b_one ? RES_W'(1) : rdata_b);
  end

  // fold at launch, then quotient estimate, subtract, compare-subtract
  always_comb begin
    fold_next  = FOLD_W'(acc[ACC_W-1:FOLD_SH]) * FOLD_W'(FOLD_K) +
                 FOLD_W'(acc[FOLD_SH-1:0]);
    recip_prod = (FOLD_W+RECIP_W)'(fold) * (FOLD_W+RECIP_W)'(RECIP);
    // difference is below twice the modulus, so the low bits are exact
    quo_mul    = quo * Q_W'(MODULUS);
    part_next  = fold[RES_W:0] - quo_mul[RES_W:0];
    part_sub   = part - {1'b0, MODULUS};
  end

  assign red_busy = (stg != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      stg  <= '0;
      rem  <= '0;
    end else begin
      p1_v <= ctl.issue;
      p2_v <= p1_v;
      if (ctl.red_go) begin
        stg <= RED_STEPS'(1);
        rem <= '0;
      end else begin
        stg <= {stg[RED_STEPS-2:0], 1'b0};
        if (stg[RED_STEPS-1]) begin
          rem <= (part >= {1'b0, MODULUS}) ? part_sub[RES_W-1:0] : part[RES_W-1:0];
        end
      end
    end
    p1_hz    <= ctl.hz;
    p1_a_one <= ctl.a_one;
    p1_b_one <= ctl.b_one;
    prod     <= a_val * b_val;
    if (ctl.clr) begin
      acc <= '0;
    end else if (p2_v) begin
      acc <= acc + ACC_W'(prod);
    end
    if (ctl.red_go) begin
      fold <= fold_next;
    end
    if (stg[0]) begin
      quo <= recip_prod[FOLD_W+RECIP_W-1:RECIP_SH];
    end
    if (stg[1]) begin
      part <= part_next;
    end
  end

  always_comb begin
    sts.pipe_empty = !p1_v && !p2_v;
    sts.red_busy   = red_busy;
    sts.residue    = rem;
  end

  `FTC_ASSERT_IMP(a_go_empty, ctl.red_go, !p1_v && !p2_v, "reduce started with terms in flight")
  `FTC_ASSERT_IMP(a_no_issue_red, ctl.issue, !red_busy, "term issued during reduction")
  `FTC_ASSERT_NXT(a_go_busy, ctl.red_go, red_busy && (rem == '0), "reducer did not load")
  `FTC_ASSERT_IMP(a_rem_range, 1'b1, rem < MODULUS, "residue out of range")

endmodule

`default_nettype wire

/* hw/rtl/full_tree_height_count_unit.sv */
// Top level of the full tree height count unit: sequencer, memo RAM, MAC unit.
// Depends on ftc_pkg, ftc_ram, ftc_mac and the assertion macro header.
`default_nettype none
`include "full_tree_height_count_unit_macros.svh"

// Counts full binary trees with node_count nodes and exactly tree_height
// levels, mod 9901. A query is taken when start is high and busy is low; busy
// then stays high until the answer is shown. The answer appears on tree_count
// with done high for exactly one cycle and must be captured then: there is no
// way to hold it. The unit keeps a memo of C(n,h), the count for at most h
// levels, in a 32768 x 14 RAM that survives across queries, plus a record of
// the filled region (all odd n up to fill_n for every h up to fill_k). A query
// with even n, n <= 1 or zero height goes straight to the answer read, through
// S_RDANS and S_ANS. A query with odd n >= 3 and nonzero height whose n and k
// lie inside that region walks the filled levels once, one S_ENTRY visit per
// level, then reads its answer. Otherwise the region is grown to the larger n
// and larger k, computing each missing entry with the shared
// multiply-accumulate unit: a setup state that clears the accumulator, one
// product term per cycle ((m-1)/2 terms for entry m), a pipe drain (its end
// folds the raw sum), the mod-9901 reduction (quotient estimate, subtract,
// compare-subtract) and a RAM write. A cold query at n = 255, k = 127 spends
// almost all its time in that unit; the RAM needs no clearing pass since
// nothing outside the filled region is ever used.
module full_tree_height_count_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [ftc_pkg::N_W-1:0]   node_count,
  input  wire logic [ftc_pkg::H_W-1:0]   tree_height,
  output logic                           done,
  output logic      [ftc_pkg::RES_W-1:0] tree_count
);
  import ftc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENTRY,
    S_MAC,
    S_DRAIN,
    S_REDUCE,
    S_RDANS,
    S_ANS
  } state_t;

  state_t            state;
  logic [N_W-1:0]    node_reg, tgt_n, fill_n, m_reg, i_reg;
  logic [H_W-1:0]    hgt_reg, tgt_k, fill_k, h_reg;

  ftc_mac_ctl_t      mac_ctl;
  ftc_mac_sts_t      mac_sts;

  logic              ram_we;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [RES_W-1:0]  rdata_a, rdata_b;

  logic [H_W-1:0]    h_dn;
  logic [N_W-1:0]    b_idx;
  logic              covered, row_end, last_row, i_last, advance, need_fill;
  logic [N_W:0]      m_step;
  logic [RES_W-1:0]  hi_val, lo_val;
  logic [RES_W:0]    diff;

  // sweep bookkeeping
  always_comb begin
    h_dn     = h_reg - H_W'(1);
    b_idx    = m_reg - N_W'(1) - i_reg;      // right subtree size, odd
    covered  = (m_reg <= fill_n) && (h_reg <= fill_k);
    // a covered entry jumps straight past the filled part of the row
    m_step   = covered ? ({1'b0, fill_n} + (N_W+1)'(2)) : ({1'b0, m_reg} + (N_W+1)'(2));
    row_end  = m_step > {1'b0, tgt_n};
    last_row = (h_reg == tgt_k);
    i_last   = (i_reg == m_reg - N_W'(2));
    advance  = ((state == S_ENTRY) && covered) ||
               ((state == S_REDUCE) && !mac_sts.red_busy);
    need_fill = node_count[0] && (node_count != N_W'(1)) && (tree_height != '0);
  end

  // MAC control and RAM ports
  always_comb begin
    mac_ctl.issue  = (state == S_MAC);
    mac_ctl.clr    = (state == S_ENTRY);
    mac_ctl.red_go = (state == S_DRAIN) && mac_sts.pipe_empty;
    mac_ctl.hz     = (h_dn == '0);
    mac_ctl.a_one  = (i_reg == N_W'(1));
    mac_ctl.b_one  = (b_idx == N_W'(1));

    ram_we = (state == S_REDUCE) && !mac_sts.red_busy;
    waddr  = {m_reg, h_reg};
    if (state == S_RDANS) begin
      raddr_a = {node_reg, hgt_reg};
      raddr_b = {node_reg, hgt_reg - H_W'(1)};
    end else begin
      raddr_a = {i_reg, h_dn};
      raddr_b = {b_idx, h_dn};
    end
  end

  // answer: C(n,k) - C(n,k-1), wrapped into the residue range
  always_comb begin
    if ((node_reg == '0) || !node_reg[0] || (hgt_reg == '0)) begin
      hi_val = '0;
    end else if (node_reg == N_W'(1)) begin
      hi_val = RES_W'(1);
    end else begin
      hi_val = rdata_a;
    end
    if ((node_reg == '0) || !node_reg[0] || (hgt_reg <= H_W'(1))) begin
      lo_val = '0;
    end else if (node_reg == N_W'(1)) begin
      lo_val = RES_W'(1);
    end else begin
      lo_val = rdata_b;
    end
    diff = (hi_val >= lo_val) ? ({1'b0, hi_val} - {1'b0, lo_val})
                              : ({1'b0, hi_val} + {1'b0, MODULUS} - {1'b0, lo_val});
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      fill_n <= N_W'(1);
      fill_k <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            node_reg <= node_count;
            hgt_reg  <= tree_height;
            tgt_n    <= (node_count > fill_n) ? node_count : fill_n;
            tgt_k    <= (tree_height > fill_k) ? tree_height : fill_k;
            m_reg    <= N_W'(3);
            h_reg    <= H_W'(1);
            state    <= need_fill ? S_ENTRY : S_RDANS;
          end
        end
        S_ENTRY: begin
          if (!covered) begin
            i_reg <= N_W'(1);
            state <= S_MAC;
          end
        end
        S_MAC: begin
          i_reg <= i_reg + N_W'(2);
          if (i_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (mac_sts.pipe_empty) begin
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          // advance below
        end
        S_RDANS: begin
          state <= S_ANS;
        end
        S_ANS: begin
          done       <= 1'b1;
          tree_count <= diff[RES_W-1:0];
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (advance) begin
        if (row_end) begin
          m_reg <= N_W'(3);
          if (last_row) begin
            fill_n <= tgt_n;
            fill_k <= tgt_k;
            state  <= S_RDANS;
          end else begin
            h_reg <= h_reg + H_W'(1);
            state <= S_ENTRY;
          end
        end else begin
          m_reg <= m_step[N_W-1:0];
          state <= S_ENTRY;
        end
      end
    end
  end

  ftc_ram #(
    .WIDTH (RES_W),
    .DEPTH (MEMO_DEPTH)
  ) u_memo (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (waddr),
    .wdata   (mac_sts.residue),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  ftc_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .sts     (mac_sts)
  );

  `FTC_ASSERT_NXT(a_done_pulse, done, !done, "done held longer than one cycle")
  `FTC_ASSERT_NXT(a_take_busy, start && !busy, busy, "query taken but busy stayed low")
  `FTC_ASSERT_IMP(a_wr_region, ram_we, (m_reg >= N_W'(3)) && (h_reg >= H_W'(1)) && !covered, "memo write outside missing region")
  `FTC_ASSERT_IMP(a_ans_range, done, tree_count < MODULUS, "answer out of range")

endmodule

`default_nettype wire
